// ===== rtl/vde_pkg.sv =====
// ----------------------------------------------------------------------------
// vde_pkg
// Shared types and constants of the vector distance engine: metric codes,
// controller states, the command and status bundles, and iteration counts.
// ----------------------------------------------------------------------------
package vde_pkg;

    localparam int ELEM_W    = 16;
    localparam int DIFF_W    = 16;
    localparam int DEN_W     = 17;
    localparam int QUOT_W    = 17;
    localparam int TERM_W    = 32;
    localparam int ACC_W     = 48;
    localparam int DIST_W    = 32;
    localparam int FRAC_BITS = 16;

    localparam int DIV_STEPS  = QUOT_W;
    localparam int SQRT_STEPS = ACC_W / 2;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    localparam logic [CNT_W-1:0] DIV_CNT_INIT  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_CNT_INIT = CNT_W'(SQRT_STEPS - 1);

    localparam logic [ACC_W-1:0] SQRT_BIT_INIT = ACC_W'(1) << (ACC_W - 2);

    typedef enum logic [1:0] {
        METRIC_EUCLIDEAN = 2'd0,
        METRIC_MANHATTAN = 2'd1,
        METRIC_CHEBYSHEV = 2'd2,
        METRIC_CANBERRA  = 2'd3
    } metric_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TERM,
        ST_ACC,
        ST_FINISH,
        ST_SQRT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic term_load;
        logic acc_update;
        logic sqrt_init;
        logic sqrt_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        metric_t cfg_metric;
        metric_t item_metric;
        logic    item_last;
        logic    out_busy;
    } status_t;

endpackage

// ===== rtl/vde_ctrl.sv =====
// ----------------------------------------------------------------------------
// vde_ctrl
// Sequencer of the vector distance engine: per pair, divide (canberra),
// term, accumulate; after the last pair, square root (euclidean) and emit.
// ----------------------------------------------------------------------------
module vde_ctrl
    import vde_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (status.cfg_metric == METRIC_CANBERRA) begin
                        state_next = ST_DIV;
                        cnt_next   = DIV_CNT_INIT;
                    end else begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_TERM;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_TERM: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = status.item_last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (status.item_metric == METRIC_EUCLIDEAN) begin
                    state_next = ST_SQRT;
                    cnt_next   = SQRT_CNT_INIT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SQRT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_TERM: begin
                cmd.term_load = 1'b1;
            end
            ST_ACC: begin
                cmd.acc_update = 1'b1;
            end
            ST_FINISH: begin
                cmd.sqrt_init = (status.item_metric == METRIC_EUCLIDEAN);
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/vde_datapath.sv =====
// ----------------------------------------------------------------------------
// vde_datapath
// Datapath of the vector distance engine: metric register, element
// magnitudes, restoring divider, running accumulator, bit-pair square root
// and the output register.
// ----------------------------------------------------------------------------
module vde_datapath
    import vde_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_data,
    input  logic signed [ELEM_W-1:0] s_elem_a,
    input  logic signed [ELEM_W-1:0] s_elem_b,
    input  logic                     s_last_elem,
    input  cmd_t                     cmd,
    output status_t                  status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIST_W-1:0]        m_distance
);

    metric_t             metric_reg;
    metric_t             item_metric_reg;
    logic                item_last_reg;
    logic [DIFF_W-1:0]   d_reg;
    logic [DEN_W-1:0]    den_reg;
    logic                den_zero_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]   nlo_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [TERM_W-1:0]   term_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    sq_v_reg;
    logic [ACC_W-1:0]    sq_root_reg;
    logic [ACC_W-1:0]    sq_bit_reg;
    logic                m_valid_reg;
    logic [DIST_W-1:0]   m_distance_reg;

    logic signed [ELEM_W:0] diff;
    logic [ELEM_W:0]        diff_mag;
    logic [ELEM_W-1:0]      abs_a;
    logic [ELEM_W-1:0]      abs_b;
    logic [DEN_W-1:0]       den_next;
    logic [DIFF_W-1:0]      d_next;
    logic [DEN_W:0]         div_trial;
    logic                   div_ge;
    logic [ACC_W:0]         acc_sum;
    logic [ACC_W-1:0]       acc_next;
    logic [ACC_W-1:0]       sq_sum;
    logic                   sq_ge;
    logic [DIST_W-1:0]      result;

    // element magnitudes
    always_comb begin
        diff     = $signed({s_elem_a[ELEM_W-1], s_elem_a})
                 - $signed({s_elem_b[ELEM_W-1], s_elem_b});
        diff_mag = diff[ELEM_W] ? (~diff + (ELEM_W+1)'(1)) : diff;
        d_next   = diff_mag[DIFF_W-1:0];
        abs_a    = s_elem_a[ELEM_W-1] ? (~s_elem_a + ELEM_W'(1)) : s_elem_a;
        abs_b    = s_elem_b[ELEM_W-1] ? (~s_elem_b + ELEM_W'(1)) : s_elem_b;
        den_next = {1'b0, abs_a} + {1'b0, abs_b};
    end

    // divider step
    always_comb begin
        div_trial = {rem_reg, nlo_reg[QUOT_W-1]};
        div_ge    = div_trial >= {1'b0, den_reg};
    end

    // accumulate
    always_comb begin
        acc_sum  = {1'b0, acc_reg} + {{(ACC_W+1-TERM_W){1'b0}}, term_reg};
        acc_next = acc_reg;
        case (item_metric_reg)
            METRIC_CHEBYSHEV: begin
                if ({{(ACC_W-DIFF_W){1'b0}}, d_reg} > acc_reg) begin
                    acc_next = {{(ACC_W-DIFF_W){1'b0}}, d_reg};
                end
            end
            default: begin
                acc_next = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
            end
        endcase
    end

    // square root step
    always_comb begin
        sq_sum = sq_root_reg + sq_bit_reg;
        sq_ge  = sq_v_reg >= sq_sum;
    end

    always_comb begin
        if (item_metric_reg == METRIC_EUCLIDEAN) begin
            result = sq_root_reg[DIST_W-1:0];
        end else if (acc_reg[ACC_W-1:DIST_W] != '0) begin
            result = {DIST_W{1'b1}};
        end else begin
            result = acc_reg[DIST_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg  <= METRIC_EUCLIDEAN;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                metric_reg <= metric_t'(cfg_data);
            end
            if (cmd.acc_update) begin
                acc_reg <= acc_next;
            end else if (cmd.emit) begin
                acc_reg <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_metric_reg <= metric_reg;
            item_last_reg   <= s_last_elem;
            d_reg           <= d_next;
            den_reg         <= den_next;
            den_zero_reg    <= (den_next == '0);
            rem_reg         <= {2'b00, d_next[DIFF_W-1:1]};
            nlo_reg         <= {d_next[0], {FRAC_BITS{1'b0}}};
            quot_reg        <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? DEN_W'(div_trial - {1'b0, den_reg}) : div_trial[DEN_W-1:0];
            nlo_reg  <= {nlo_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], div_ge};
        end
        if (cmd.term_load) begin
            case (item_metric_reg)
                METRIC_EUCLIDEAN: begin
                    term_reg <= {{(TERM_W-DIFF_W){1'b0}}, d_reg}
                              * {{(TERM_W-DIFF_W){1'b0}}, d_reg};
                end
                METRIC_CANBERRA: begin
                    term_reg <= den_zero_reg ? '0
                              : {{(TERM_W-QUOT_W){1'b0}}, quot_reg};
                end
                default: begin
                    term_reg <= {{(TERM_W-DIFF_W){1'b0}}, d_reg};
                end
            endcase
        end
        if (cmd.sqrt_init) begin
            sq_v_reg    <= acc_reg;
            sq_root_reg <= '0;
            sq_bit_reg  <= SQRT_BIT_INIT;
        end else if (cmd.sqrt_step) begin
            if (sq_ge) begin
                sq_v_reg    <= sq_v_reg - sq_sum;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end else begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.emit) begin
            m_distance_reg <= result;
        end
    end

    assign status.cfg_metric  = metric_reg;
    assign status.item_metric = item_metric_reg;
    assign status.item_last   = item_last_reg;
    assign status.out_busy    = m_valid_reg && !m_ready;

    assign m_valid    = m_valid_reg;
    assign m_distance = m_distance_reg;

endmodule

// ===== rtl/vector_distance_engine_top.sv =====
// ----------------------------------------------------------------------------
// vector_distance_engine_top
// Distance between two streamed Q8.8 vectors under a selectable metric:
// euclidean, manhattan, chebyshev or canberra.
//
//   channel  direction  ports
//   cfg      in         cfg_valid, cfg_ready, cfg_data (metric)
//   s        in         s_valid, s_ready, s_elem_a, s_elem_b, s_last_elem
//   m        out        m_valid, m_ready, m_distance
//
// one element pair at a time: term and accumulate, after a 17-step restoring
// divider for canberra; a last pair adds the finish and emit states, with a
// bit-pair square root between them for euclidean
// reset clears the metric, the accumulator and the output valid flag
// a result waiting on m_ready holds the next last pair, and the input with it
// ----------------------------------------------------------------------------
module vector_distance_engine_top
    import vde_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [ELEM_W-1:0] s_elem_a,
    input  logic signed [ELEM_W-1:0] s_elem_b,
    input  logic                     s_last_elem,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIST_W-1:0]        m_distance
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    vde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vde_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .s_elem_a    (s_elem_a),
        .s_elem_b    (s_elem_b),
        .s_last_elem (s_last_elem),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance)
    );

endmodule

// ===== rtl/vde_checker.sv =====
// ----------------------------------------------------------------------------
// vde_checker
// Port-level checks of the vector distance engine, bound to the top level.
// ----------------------------------------------------------------------------
module vde_checker
    import vde_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              cfg_ready,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DIST_W-1:0] m_distance
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance))
        else $error("stalled result changed");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one pair in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // no result appears right after a pair is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result without processing time");

    // metric writes never stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port stalled");

endmodule

bind vector_distance_engine_top vde_checker u_vde_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .cfg_ready  (cfg_ready),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_distance (m_distance)
);
